FILE: hdl/dsfd_pkg.sv
// Shared types, constants and coefficient tables for the dual stereo feedback delay.
`timescale 1ns / 1ps

package dsfd_pkg;

  // Default sizes.
  localparam int SampleBitsDef = 24;
  localparam int MaxDelayDef   = 65536;

  // Register field widths.
  localparam int LenW     = 17;
  localparam int LevelsW  = 21;
  localparam int CodeW    = 7;
  localparam int RegDataW = 32;
  localparam int PaddrW   = 5;

  // Fixed point: coefficients are Q1.16.
  localparam int FracBits = 16;
  localparam int QOne     = 65536;
  localparam int RndHalf  = 32768;
  localparam int QDiv     = 127;
  localparam int FbShift  = 9;
  localparam int CoefW    = 17;
  localparam int MulCoefW = 18;

  // Register reset values.
  localparam int LenAReset    = 13585;
  localparam int LenBReset    = 10673;
  localparam int LevelsAReset = 1228859;
  localparam int LevelsBReset = 1245116;

  typedef enum logic [2:0] {
    REG_A_LEN    = 3'd0,
    REG_B_LEN    = 3'd1,
    REG_A_LEVELS = 3'd2,
    REG_B_LEVELS = 3'd3,
    REG_CROSS    = 3'd4,
    REG_DAMP     = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_RUN,
    ST_WB,
    ST_OUT
  } dsfd_state_e;

  typedef enum logic [3:0] {
    CH_IDLE,
    CH_GP,
    CH_MIX0,
    CH_MIX1,
    CH_IN,
    CH_FB,
    CH_D,
    CH_DH,
    CH_Y
  } chan_step_e;

  // Coefficients that one channel of one line needs for an item.
  typedef struct packed {
    logic [CoefW-1:0]           gain;
    logic signed [MulCoefW-1:0] pan;
    logic [CoefW-1:0]           own_gain;
    logic [CoefW-1:0]           other_gain;
    logic [CoefW-1:0]           fb;
    logic [CoefW-1:0]           damp_new;
    logic [CoefW-1:0]           damp_old;
  } coef_t;

  typedef logic [CoefW-1:0] coef_tbl_t [128];

  // round(code * 65536 / 127) for every 7-bit code.
  function automatic coef_tbl_t build_gain_tbl();
    coef_tbl_t tbl;
    for (int i = 0; i < 128; i++) begin
      tbl[i] = CoefW'((i * QOne + QDiv / 2) / QDiv);
    end
    return tbl;
  endfunction

  // round((2 * code + 1) * 32768 / 127) for every 7-bit code.
  function automatic coef_tbl_t build_pan_tbl();
    coef_tbl_t tbl;
    for (int i = 0; i < 128; i++) begin
      tbl[i] = CoefW'(((2 * i + 1) * (QOne / 2) + QDiv / 2) / QDiv);
    end
    return tbl;
  endfunction

  localparam coef_tbl_t GainTbl = build_gain_tbl();
  localparam coef_tbl_t PanTbl  = build_pan_tbl();

endpackage

FILE: hdl/dsfd_chan.sv
// One channel of one delay line: a sequenced multiply unit for mix, feedback and damping.
`timescale 1ns / 1ps

module dsfd_chan import dsfd_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  coef_t                         coef_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic signed [SAMPLE_BITS-1:0] own_i,
  input  logic signed [SAMPLE_BITS-1:0] other_i,
  input  logic signed [SAMPLE_BITS-1:0] old_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS+1:0] d_o,
  output logic signed [SAMPLE_BITS-1:0] y_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = SB + 2;
  localparam int DW = SB + 2;
  localparam int PW = AW + MulCoefW;

  localparam logic signed [PW:0] SatHi = $signed({{(PW + 2 - SB){1'b0}}, {(SB - 1){1'b1}}});
  localparam logic signed [PW:0] SatLo = ~SatHi;

  chan_step_e step_q, step_d;

  logic signed [AW-1:0]       mul_a;
  logic signed [MulCoefW-1:0] mul_b;
  logic                       gp_ld, acc_ld, mix_ld, t_ld, d_ld, y_ld;

  logic signed [PW-1:0]       prod_q;
  logic signed [PW:0]         acc_q;
  logic signed [MulCoefW-1:0] gp_q;
  logic signed [SB-1:0]       mix_q;
  logic signed [SB:0]         t_q;
  logic signed [DW-1:0]       d_q;
  logic signed [SB-1:0]       y_q;

  logic signed [PW-1:0]       rnd_prod;
  logic signed [PW:0]         sum_all;
  logic signed [PW:0]         rnd_sum;
  logic signed [SB-1:0]       y_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= CH_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    step_d = step_q;
    mul_a  = '0;
    mul_b  = '0;
    gp_ld  = 1'b0;
    acc_ld = 1'b0;
    mix_ld = 1'b0;
    t_ld   = 1'b0;
    d_ld   = 1'b0;
    y_ld   = 1'b0;
    done_o = 1'b0;
    case (step_q)
      CH_IDLE: begin
        if (start_i) begin
          step_d = CH_GP;
        end
      end
      CH_GP: begin
        mul_a  = $signed({{(AW - CoefW){1'b0}}, coef_i.gain});
        mul_b  = coef_i.pan;
        step_d = CH_MIX0;
      end
      CH_MIX0: begin
        mul_a  = AW'(own_i);
        mul_b  = $signed({1'b0, coef_i.own_gain});
        gp_ld  = 1'b1;
        step_d = CH_MIX1;
      end
      CH_MIX1: begin
        mul_a  = AW'(other_i);
        mul_b  = $signed({1'b0, coef_i.other_gain});
        acc_ld = 1'b1;
        step_d = CH_IN;
      end
      CH_IN: begin
        mul_a  = AW'(x_i);
        mul_b  = gp_q;
        mix_ld = 1'b1;
        step_d = CH_FB;
      end
      CH_FB: begin
        mul_a  = AW'(mix_q);
        mul_b  = $signed({1'b0, coef_i.fb});
        t_ld   = 1'b1;
        step_d = CH_D;
      end
      CH_D: begin
        // The old filter state does not depend on d, so its product goes first.
        mul_a  = AW'(old_i);
        mul_b  = $signed({1'b0, coef_i.damp_old});
        d_ld   = 1'b1;
        step_d = CH_DH;
      end
      CH_DH: begin
        mul_a  = AW'(d_q);
        mul_b  = $signed({1'b0, coef_i.damp_new});
        acc_ld = 1'b1;
        step_d = CH_Y;
      end
      CH_Y: begin
        y_ld   = 1'b1;
        done_o = 1'b1;
        step_d = CH_IDLE;
      end
      default: begin
        step_d = CH_IDLE;
      end
    endcase
  end

  // Round half up by the arithmetic shift of the biased value.
  assign rnd_prod = (prod_q + PW'(RndHalf)) >>> FracBits;
  assign sum_all  = acc_q + (PW + 1)'(prod_q);
  assign rnd_sum  = sum_all >>> FracBits;

  always_comb begin
    if (rnd_sum > SatHi) begin
      y_sat = $signed({1'b0, {(SB - 1){1'b1}}});
    end else if (rnd_sum < SatLo) begin
      y_sat = $signed({1'b1, {(SB - 1){1'b0}}});
    end else begin
      y_sat = rnd_sum[SB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (acc_ld) begin
      acc_q <= (PW + 1)'(prod_q) + (PW + 1)'(RndHalf);
    end
    if (gp_ld) begin
      gp_q <= rnd_prod[MulCoefW-1:0];
    end
    if (mix_ld) begin
      mix_q <= rnd_sum[SB-1:0];
    end
    if (t_ld) begin
      t_q <= rnd_prod[SB:0];
    end
    if (d_ld) begin
      d_q <= DW'(t_q) - DW'($signed(rnd_prod[SB-1:0]));
    end
    if (y_ld) begin
      y_q <= y_sat;
    end
  end

  assign d_o = d_q;
  assign y_o = y_q;

endmodule

FILE: hdl/dual_stereo_feedback_delay_top.sv
// Top level of the dual stereo feedback delay: two delay memories, sequencer and ports.
// An accepted item passes through the fetch state, the eight steps of the shared multiplier
// in each channel unit, write-back and output load, after which m_axis_tvalid rises and
// the idle state takes the next transfer; no new item is taken before the last is loaded
// into the output register. Reset is asynchronous and active low; it restores the registers
// and empties both lines at once through one fill flag per line, so no clearing pass runs.
`timescale 1ns / 1ps

module dual_stereo_feedback_delay_top import dsfd_pkg::*; #(
  parameter int MAX_DELAY   = MaxDelayDef,
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // Input stream. tdata: in_left, in_right, then zero padding.
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  // Output stream. tdata: out_left, out_right, then zero padding.
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  output logic [((2 * SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
  // Configuration port.
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [PaddrW-1:0]                         paddr,
  input  logic [RegDataW-1:0]                       pwdata,
  output logic [RegDataW-1:0]                       prdata,
  output logic                                      pready
);

  localparam int SB    = SAMPLE_BITS;
  localparam int DataW = ((2 * SB + 7) / 8) * 8;
  localparam int AddrW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DW    = SB + 2;
  localparam int OutW  = SB + 4;
  localparam int CmpW  = (AddrW + 1 > LenW) ? AddrW + 1 : LenW;

  localparam logic [LenW-1:0] LenAInit = LenW'((LenAReset > MAX_DELAY) ? MAX_DELAY : LenAReset);
  localparam logic [LenW-1:0] LenBInit = LenW'((LenBReset > MAX_DELAY) ? MAX_DELAY : LenBReset);

  localparam logic signed [OutW-1:0] OutHi = $signed({{(OutW - SB + 1){1'b0}}, {(SB - 1){1'b1}}});
  localparam logic signed [OutW-1:0] OutLo = ~OutHi;

  // ---------------------------------------------------------------------------------------
  // Configuration registers. A register is written on the access cycle of a write
  // transfer. Length values are clamped to 1..MAX_DELAY, and any length write empties
  // both lines: positions return to zero, fill flags and filter states clear.
  // ---------------------------------------------------------------------------------------
  logic [LenW-1:0]    len_a_q, len_b_q;
  logic [LevelsW-1:0] lev_a_q, lev_b_q;
  logic [CodeW-1:0]   cross_q, damp_q;

  logic               cfg_wr;
  reg_idx_e           cfg_idx;
  logic [LenW-1:0]    wr_len, len_clamped;
  logic               len_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);
  assign wr_len  = pwdata[LenW-1:0];
  assign len_wr  = cfg_wr & ((cfg_idx == REG_A_LEN) | (cfg_idx == REG_B_LEN));

  always_comb begin
    if (wr_len == '0) begin
      len_clamped = LenW'(1);
    end else if (CmpW'(wr_len) > CmpW'(MAX_DELAY)) begin
      len_clamped = LenW'(MAX_DELAY);
    end else begin
      len_clamped = wr_len;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_A_LEN:    prdata = RegDataW'(len_a_q);
      REG_B_LEN:    prdata = RegDataW'(len_b_q);
      REG_A_LEVELS: prdata = RegDataW'(lev_a_q);
      REG_B_LEVELS: prdata = RegDataW'(lev_b_q);
      REG_CROSS:    prdata = RegDataW'(cross_q);
      REG_DAMP:     prdata = RegDataW'(damp_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a_q <= LenAInit;
      len_b_q <= LenBInit;
      lev_a_q <= LevelsW'(LevelsAReset);
      lev_b_q <= LevelsW'(LevelsBReset);
      cross_q <= '0;
      damp_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_A_LEN:    len_a_q <= len_clamped;
        REG_B_LEN:    len_b_q <= len_clamped;
        REG_A_LEVELS: lev_a_q <= pwdata[LevelsW-1:0];
        REG_B_LEVELS: lev_b_q <= pwdata[LevelsW-1:0];
        REG_CROSS:    cross_q <= pwdata[CodeW-1:0];
        REG_DAMP:     damp_q  <= pwdata[CodeW-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Coefficients. Gain, pan, cross and damping codes map to Q1.16 through constant tables.
  // Unit order is A left, A right, B left, B right; the right pan is the complement of the left.
  // ---------------------------------------------------------------------------------------
  coef_t              coef_d [4];
  coef_t              coef_q [4];
  logic [CoefW-1:0]   cross_c, damp_c;
  logic [CoefW-1:0]   pan_a, pan_b;

  assign cross_c = GainTbl[cross_q];
  assign damp_c  = GainTbl[damp_q];
  assign pan_a   = PanTbl[lev_a_q[13:7]];
  assign pan_b   = PanTbl[lev_b_q[13:7]];

  always_comb begin
    for (int u = 0; u < 4; u++) begin
      coef_d[u].own_gain   = CoefW'(QOne) - cross_c;
      coef_d[u].other_gain = cross_c;
      coef_d[u].damp_new   = CoefW'(QOne) - damp_c;
      coef_d[u].damp_old   = damp_c;
    end
    coef_d[0].gain = GainTbl[lev_a_q[20:14]];
    coef_d[1].gain = GainTbl[lev_a_q[20:14]];
    coef_d[2].gain = GainTbl[lev_b_q[20:14]];
    coef_d[3].gain = GainTbl[lev_b_q[20:14]];
    coef_d[0].fb   = CoefW'({lev_a_q[6:0], {FbShift{1'b0}}});
    coef_d[1].fb   = CoefW'({lev_a_q[6:0], {FbShift{1'b0}}});
    coef_d[2].fb   = CoefW'({lev_b_q[6:0], {FbShift{1'b0}}});
    coef_d[3].fb   = CoefW'({lev_b_q[6:0], {FbShift{1'b0}}});
    coef_d[0].pan  = $signed({1'b0, pan_a});
    coef_d[1].pan  = MulCoefW'(QOne) - $signed({1'b0, pan_a});
    coef_d[2].pan  = $signed({1'b0, pan_b});
    coef_d[3].pan  = MulCoefW'(QOne) - $signed({1'b0, pan_b});
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer. An item is read from both delay memories at the accept edge, the four
  // channel units run in lockstep, then the filtered values are written back in place,
  // the positions advance and the result moves into the output register.
  // ---------------------------------------------------------------------------------------
  dsfd_state_e state_q, state_d;

  logic in_xfer, mem_rd, unit_start, wb_en, out_load, out_free;
  logic unit_done [4];

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_free = ~m_axis_tvalid | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    mem_rd        = 1'b0;
    unit_start    = 1'b0;
    wb_en         = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          mem_rd  = 1'b1;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        unit_start = 1'b1;
        state_d    = ST_RUN;
      end
      ST_RUN: begin
        if (unit_done[0]) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        wb_en   = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // A finished result waits here only while the previous one is still unclaimed.
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Delay memories: one per line, left sample in the low half of each word. An entry
  // that has not been written since the last clear reads as zero: positions only count
  // up from zero, so every entry is written once the line's fill flag is set.
  // ---------------------------------------------------------------------------------------
  logic [2*SB-1:0]  ring_a_mem [MAX_DELAY];
  logic [2*SB-1:0]  ring_b_mem [MAX_DELAY];
  logic [2*SB-1:0]  rd_a_q, rd_b_q;
  logic [AddrW-1:0] pos_a_q, pos_b_q, pos_a_d, pos_b_d;
  logic             full_a_q, full_b_q;
  logic [CmpW-1:0]  pos_a_inc, pos_b_inc;
  logic             wrap_a, wrap_b;

  logic signed [SB-1:0] x_l_q, x_r_q;
  logic signed [SB-1:0] damp_mem_q [4];
  logic signed [SB-1:0] own_s [4];
  logic signed [SB-1:0] other_s [4];
  logic signed [SB-1:0] x_s [4];
  logic signed [DW-1:0] d_s [4];
  logic signed [SB-1:0] y_s [4];

  always_ff @(posedge clk_i) begin
    if (wb_en) begin
      ring_a_mem[pos_a_q] <= {y_s[1], y_s[0]};
      ring_b_mem[pos_b_q] <= {y_s[3], y_s[2]};
    end
    if (mem_rd) begin
      rd_a_q <= ring_a_mem[pos_a_q];
      rd_b_q <= ring_b_mem[pos_b_q];
    end
  end

  assign own_s[0]   = full_a_q ? $signed(rd_a_q[SB-1:0])    : '0;
  assign own_s[1]   = full_a_q ? $signed(rd_a_q[2*SB-1:SB]) : '0;
  assign own_s[2]   = full_b_q ? $signed(rd_b_q[SB-1:0])    : '0;
  assign own_s[3]   = full_b_q ? $signed(rd_b_q[2*SB-1:SB]) : '0;
  assign other_s[0] = own_s[1];
  assign other_s[1] = own_s[0];
  assign other_s[2] = own_s[3];
  assign other_s[3] = own_s[2];
  assign x_s[0]     = x_l_q;
  assign x_s[1]     = x_r_q;
  assign x_s[2]     = x_l_q;
  assign x_s[3]     = x_r_q;

  assign pos_a_inc = CmpW'(pos_a_q) + CmpW'(1);
  assign pos_b_inc = CmpW'(pos_b_q) + CmpW'(1);
  assign wrap_a    = pos_a_inc >= CmpW'(len_a_q);
  assign wrap_b    = pos_b_inc >= CmpW'(len_b_q);
  assign pos_a_d   = wrap_a ? '0 : pos_a_inc[AddrW-1:0];
  assign pos_b_d   = wrap_b ? '0 : pos_b_inc[AddrW-1:0];

  // Input sample and coefficient capture; these hold for the whole item.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_l_q <= $signed(s_axis_tdata[SB-1:0]);
      x_r_q <= $signed(s_axis_tdata[2*SB-1:SB]);
      for (int u = 0; u < 4; u++) begin
        coef_q[u] <= coef_d[u];
      end
    end
  end

  // Line state. A length write wins over a write-back in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_a_q  <= '0;
      pos_b_q  <= '0;
      full_a_q <= 1'b0;
      full_b_q <= 1'b0;
      for (int u = 0; u < 4; u++) begin
        damp_mem_q[u] <= '0;
      end
    end else begin
      if (wb_en) begin
        pos_a_q  <= pos_a_d;
        pos_b_q  <= pos_b_d;
        full_a_q <= full_a_q | wrap_a;
        full_b_q <= full_b_q | wrap_b;
        for (int u = 0; u < 4; u++) begin
          damp_mem_q[u] <= y_s[u];
        end
      end
      if (len_wr) begin
        pos_a_q  <= '0;
        pos_b_q  <= '0;
        full_a_q <= 1'b0;
        full_b_q <= 1'b0;
        for (int u = 0; u < 4; u++) begin
          damp_mem_q[u] <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Channel units.
  // ---------------------------------------------------------------------------------------
  for (genvar u = 0; u < 4; u++) begin : g_chan
    dsfd_chan #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_chan (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (unit_start),
      .coef_i  (coef_q[u]),
      .x_i     (x_s[u]),
      .own_i   (own_s[u]),
      .other_i (other_s[u]),
      .old_i   (damp_mem_q[u]),
      .done_o  (unit_done[u]),
      .d_o     (d_s[u]),
      .y_o     (y_s[u])
    );
  end

  // ---------------------------------------------------------------------------------------
  // Output: twice the sum of the two lines' unfiltered values, saturated per channel.
  // ---------------------------------------------------------------------------------------
  logic signed [OutW-1:0] sum_l, sum_r;
  logic signed [SB-1:0]   out_l, out_r;
  logic [DataW-1:0]       m_tdata_q;
  logic                   m_valid_q;

  assign sum_l = (OutW'(d_s[0]) + OutW'(d_s[2])) <<< 1;
  assign sum_r = (OutW'(d_s[1]) + OutW'(d_s[3])) <<< 1;

  always_comb begin
    if (sum_l > OutHi) begin
      out_l = $signed({1'b0, {(SB - 1){1'b1}}});
    end else if (sum_l < OutLo) begin
      out_l = $signed({1'b1, {(SB - 1){1'b0}}});
    end else begin
      out_l = sum_l[SB-1:0];
    end
    if (sum_r > OutHi) begin
      out_r = $signed({1'b0, {(SB - 1){1'b1}}});
    end else if (sum_r < OutLo) begin
      out_r = $signed({1'b1, {(SB - 1){1'b0}}});
    end else begin
      out_r = sum_r[SB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_tdata_q <= DataW'({out_r, out_l});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------

  // The channel units finish only while the sequencer waits for them.
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (unit_done[0] || unit_done[1] || unit_done[2] || unit_done[3]) |-> (state_q == ST_RUN))
    else $error("channel unit finished outside the run state");

  // Each position stays below its line length.
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CmpW'(pos_a_q) < CmpW'(len_a_q)) && (CmpW'(pos_b_q) < CmpW'(len_b_q)))
    else $error("delay position outside the line length");

  // A length write empties both lines.
  a_len_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_wr |=> (pos_a_q == '0) && (pos_b_q == '0) && !full_a_q && !full_b_q)
    else $error("length write did not clear the lines");

  // Positions move only on a write-back or a length write.
  a_pos_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!wb_en && !len_wr) |=> $stable(pos_a_q) && $stable(pos_b_q))
    else $error("delay position changed without a write-back");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of the dual stereo feedback delay: directed and random streams against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import dsfd_pkg::*;

  localparam int SW       = SampleBitsDef;
  localparam int DataW    = ((2 * SW + 7) / 8) * 8;
  localparam int RingLen  = MaxDelayDef;
  localparam longint SatHi = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SatLo = -SatHi - 1;

  // Register indexes beyond the last real register; writes there must be ignored.
  localparam logic [2:0] RegSpare0 = 3'd6;
  localparam logic [2:0] RegSpare1 = 3'd7;

  // Idling modes of both stream sides.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } pair_t;

  // Predicts the echo output of every accepted input pair and checks the output stream.
  class echo_scoreboard;
    int      ring [4][RingLen];   // A left, A right, B left, B right
    longint  pos [2];
    longint  len [2];
    logic [LevelsW-1:0] levels [2];
    logic [CodeW-1:0]   cross_code;
    logic [CodeW-1:0]   damp;
    longint  damp_mem [4];
    pair_t   expected_pairs [$];
    int unsigned errors;

    function new();
      errors     = 0;
      len[0]     = LenAReset;
      len[1]     = LenBReset;
      levels[0]  = LevelsAReset;
      levels[1]  = LevelsBReset;
      cross_code = '0;
      damp       = '0;
      clear_lines();
    endfunction

    function void clear_lines();
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < RingLen; k++) begin
          ring[r][k] = 0;
        end
        damp_mem[r] = 0;
      end
      pos[0] = 0;
      pos[1] = 0;
    endfunction

    // Half-up rounding of a Q1.16 product, which is a floor after adding one half.
    function longint rnd16(longint p);
      return (p + RndHalf) >>> FracBits;
    endfunction

    function longint sat(longint v);
      if (v > SatHi) return SatHi;
      if (v < SatLo) return SatLo;
      return v;
    endfunction

    function longint q127(longint code);
      return (code * QOne + QDiv / 2) / QDiv;
    endfunction

    function longint clamp_len(logic [LenW-1:0] v);
      if (v == 0) return 1;
      if (v > RingLen) return RingLen;
      return longint'(v);
    endfunction

    function void write_reg(logic [2:0] idx, logic [RegDataW-1:0] value);
      case (idx)
        REG_A_LEN: begin
          len[0] = clamp_len(value[LenW-1:0]);
          clear_lines();
        end
        REG_B_LEN: begin
          len[1] = clamp_len(value[LenW-1:0]);
          clear_lines();
        end
        REG_A_LEVELS: levels[0] = value[LevelsW-1:0];
        REG_B_LEVELS: levels[1] = value[LevelsW-1:0];
        REG_CROSS:    cross_code = value[CodeW-1:0];
        REG_DAMP:     damp = value[CodeW-1:0];
        default: ;
      endcase
    endfunction

    // One delay line: returns its two line values and writes the damped values back.
    function void run_line(int ln, longint xl, longint xr, output longint dl, output longint dr);
      longint k, g, p, f, gpl, gpr, c, h, ol, orr, ml, mr, yl, yr;
      k = pos[ln];
      if (k >= len[ln]) k = 0;
      g   = q127(longint'(levels[ln][20:14]));
      p   = ((2 * longint'(levels[ln][13:7]) + 1) * (QOne / 2) + QDiv / 2) / QDiv;
      f   = longint'(levels[ln][6:0]) <<< FbShift;
      gpl = rnd16(g * p);
      gpr = rnd16(g * (QOne - p));
      c   = q127(longint'(cross_code));
      h   = QOne - q127(longint'(damp));
      ol  = ring[2 * ln][k];
      orr = ring[2 * ln + 1][k];
      ml  = rnd16(ol * (QOne - c) + orr * c);
      mr  = rnd16(orr * (QOne - c) + ol * c);
      dl  = rnd16(xl * gpl) - rnd16(ml * f);
      dr  = rnd16(xr * gpr) - rnd16(mr * f);
      yl  = sat(rnd16(dl * h + damp_mem[2 * ln] * (QOne - h)));
      yr  = sat(rnd16(dr * h + damp_mem[2 * ln + 1] * (QOne - h)));
      ring[2 * ln][k]     = int'(yl);
      ring[2 * ln + 1][k] = int'(yr);
      damp_mem[2 * ln]     = yl;
      damp_mem[2 * ln + 1] = yr;
      k++;
      if (k >= len[ln]) k = 0;
      pos[ln] = k;
    endfunction

    function void note_input(logic [SW-1:0] in_l, logic [SW-1:0] in_r);
      longint xl, xr, al, ar, bl, br;
      pair_t  res;
      xl = longint'($signed(in_l));
      xr = longint'($signed(in_r));
      run_line(0, xl, xr, al, ar);
      run_line(1, xl, xr, bl, br);
      res.left  = SW'(sat(2 * (al + bl)));
      res.right = SW'(sat(2 * (ar + br)));
      expected_pairs.push_back(res);
    endfunction

    function void check_result(logic [DataW-1:0] data);
      pair_t exp_pair;
      logic signed [SW-1:0] got_l, got_r;
      got_l = data[SW-1:0];
      got_r = data[2*SW-1:SW];
      if (expected_pairs.size() == 0) begin
        $display("%0t: output transfer with nothing expected, left %0d right %0d",
                 $time, got_l, got_r);
        errors++;
        return;
      end
      exp_pair = expected_pairs.pop_front();
      if (got_l !== exp_pair.left) begin
        $display("%0t: out_left expected %0d, actual %0d", $time, exp_pair.left, got_l);
        errors++;
      end
      if (got_r !== exp_pair.right) begin
        $display("%0t: out_right expected %0d, actual %0d", $time, exp_pair.right, got_r);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [DataW-1:0]   s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [DataW-1:0]   m_axis_tdata;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PaddrW-1:0]  paddr;
  logic [RegDataW-1:0] pwdata;
  logic [RegDataW-1:0] prdata;
  logic               pready;

  echo_scoreboard sb;
  int gap_pct;
  int stall_pct;
  logic [RegDataW-1:0] last_len [2];

  dual_stereo_feedback_delay_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Output side: check each transfer and choose the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin gap_pct = 62; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 62; end
      default:       begin gap_pct = 16; stall_pct = 16; end
    endcase
  endtask

  task automatic reg_write(logic [2:0] idx, logic [RegDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    if (idx == REG_A_LEN) last_len[0] = value;
    if (idx == REG_B_LEN) last_len[1] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends one stereo pair, with random idle cycles before it, and records it once accepted.
  task automatic send_pair(logic [SW-1:0] in_l, logic [SW-1:0] in_r);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DataW'({in_r, in_l});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(in_l, in_r);
  endtask

  // Waits until every expected pair has come out and the block has settled.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_pairs.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  function automatic logic [SW-1:0] pick_sample();
    int sel;
    logic signed [SW-1:0] v;
    sel = $urandom_range(9);
    v   = SW'($urandom);
    case (sel)
      0: v = SW'(SatHi);
      1: v = SW'(SatLo);
      2: v = '0;
      default: v = v >>> $urandom_range(10);
    endcase
    return v;
  endfunction

  function automatic logic [RegDataW-1:0] pick_length();
    int sel;
    logic [RegDataW-1:0] v;
    sel = $urandom_range(19);
    v   = $urandom;
    if (sel < 12) v[LenW-1:0] = LenW'($urandom_range(64, 1));
    else if (sel < 14) v[LenW-1:0] = '0;
    else if (sel < 16) v[LenW-1:0] = LenW'(RingLen);
    else if (sel < 18) v[LenW-1:0] = '1;
    else v[LenW-1:0] = LenW'($urandom_range(RingLen, 1));
    return v;
  endfunction

  function automatic logic [RegDataW-1:0] pick_code(int width);
    int sel;
    logic [RegDataW-1:0] v;
    sel = $urandom_range(9);
    v   = $urandom;
    if (sel < 2) v = v & ~((RegDataW'(1) << width) - 1);
    else if (sel < 4) v = v | ((RegDataW'(1) << width) - 1);
    return v;
  endfunction

  // Length writes are skipped now and then, so the rings carry over into the next phase.
  task automatic random_config();
    for (int ln = 0; ln < 2; ln++) begin
      int sel;
      sel = $urandom_range(19);
      if (sel < 13) reg_write(ln == 0 ? REG_A_LEN : REG_B_LEN, pick_length());
      else if (sel < 16) reg_write(ln == 0 ? REG_A_LEN : REG_B_LEN, last_len[ln]);
    end
    reg_write(REG_A_LEVELS, pick_code(LevelsW));
    reg_write(REG_B_LEVELS, pick_code(LevelsW));
    reg_write(REG_CROSS, pick_code(CodeW));
    reg_write(REG_DAMP, pick_code(CodeW));
    reg_write($urandom_range(1) ? RegSpare0 : RegSpare1, $urandom);
  endtask

  initial begin
    sb = new();
    last_len[0] = LenAReset;
    last_len[1] = LenBReset;
    gap_pct   = 0;
    stall_pct = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings: full-scale and sign extremes.
    send_pair('0, '0);
    send_pair(SW'(SatHi), SW'(SatHi));
    send_pair(SW'(SatLo), SW'(SatLo));
    send_pair(SW'(SatHi), SW'(SatLo));
    send_pair(SW'(SatLo), SW'(SatHi));
    send_pair(SW'(1), SW'(-1));
    send_pair('1, '0);
    drain();

    // Extreme settings: a zero length clamps to one, an oversized one to the maximum,
    // excess bits are dropped and spare register addresses do nothing.
    reg_write(REG_A_LEN, '0);
    reg_write(REG_B_LEN, 32'hFFFF_FFFF);
    reg_write(REG_A_LEVELS, 32'hFFFF_FFFF);
    reg_write(REG_B_LEVELS, 32'h001F_C07F);
    reg_write(REG_CROSS, 32'hFFFF_FFFF);
    reg_write(REG_DAMP, '0);
    reg_write(RegSpare0, 32'hFFFF_FFFF);
    reg_write(RegSpare1, 32'h5555_AAAA);
    send_pair(SW'(SatHi), SW'(SatHi));
    send_pair(SW'(SatHi), SW'(SatLo));
    send_pair(SW'(SatLo), SW'(SatLo));
    send_pair('0, '0);
    send_pair(SW'(SatLo), SW'(SatHi));
    send_pair('0, '0);
    drain();

    // Fully damped setting: the filters hold their cleared state, so only the dry path shows.
    reg_write(REG_A_LEN, 32'd2);
    reg_write(REG_DAMP, 32'd127);
    reg_write(REG_CROSS, '0);
    send_pair(SW'(SatHi), SW'(SatLo));
    send_pair(SW'(12345), SW'(-54321));
    send_pair('0, '0);
    drain();

    // Random phases, each under its own settings and idling mode.
    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      set_idling(idle_mode_e'(ph % 4));
      for (int n = 0; n < 136; n++) begin
        send_pair(pick_sample(), pick_sample());
      end
      drain();
      set_idling(IDLE_NONE);
    end

    repeat (20) @(posedge clk_i);
    if (sb.expected_pairs.size() != 0) begin
      $display("%0t: %0d expected output pairs never arrived", $time, sb.expected_pairs.size());
    end
    if (sb.errors == 0 && sb.expected_pairs.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
